// File: rtl/tcw_pkg.sv
// shared types and constants for the text console writer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;
   localparam int OPQ_DEPTH       = 2;

   localparam logic [7:0]  CODE_NULL      = 8'd0;
   localparam logic [7:0]  CODE_BACKSPACE = 8'd8;
   localparam logic [7:0]  CODE_NEWLINE   = 8'd10;
   localparam logic [7:0]  CODE_SPACE     = 8'd32;
   localparam logic [7:0]  RESET_COLOR    = 8'h07;
   localparam logic [15:0] RESET_CELL     = 16'h0720;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [1:0] OP_READ      = 2'd0;
   localparam logic [1:0] OP_PRINT     = 2'd1;
   localparam logic [1:0] OP_NEWLINE   = 2'd2;
   localparam logic [1:0] OP_BACKSPACE = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [4:0]  cursor_row_out;
      logic [6:0]  cursor_col_out;
      logic [10:0] cursor_offset;
      logic [15:0] cell_value;
   } rsp_type;

   // classified command as it travels from front to back
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
      logic        in_range;
   } op_type;

endpackage

// File: rtl/text_console_writer_unit.sv
// top level of the text console writer: front end, command queue, executor
// depends on tcw_pkg, tcw_front, tcw_opq, tcw_back
`timescale 1ns / 1ps

// Usage
//   Commands enter through a queue-style port: a transaction is taken when
//   req_push is high and req_full is low. A put of character 0 is taken and
//   dropped with no result; every other command gives one result.
//   Results leave the same way: while rsp_empty is low the oldest result is
//   on rsp_data, and rsp_pop takes it.
//   csr_we/csr_wdata set the attribute byte used for written and blanked
//   cells; write it only while no command is in flight.
// Timing
//   A read, character write, newline without scroll or backspace is taken
//   from the queue in the idle state and carried out in the execute state,
//   which registers its result. A scroll copies the screen one cell per
//   cycle and then blanks the last row.
// Reset
//   Reset homes the cursor, sets the attribute to light grey on black and
//   then fills the screen with spaces, one cell per cycle; meanwhile
//   commands queue up but are not executed.
// Stalls
//   When rsp_pop stays low the finished result is held; the command queue
//   keeps taking transactions until it fills, then req_full rises.

module text_console_writer_unit import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   op_type front_op, queue_op;
   logic   op_push, op_full, op_pop, op_empty;

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_data (req_data),
      .req_push (req_push),
      .req_full (req_full),
      .op_data  (front_op),
      .op_push  (op_push),
      .op_full  (op_full)
   );

   tcw_opq u_opq (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (front_op),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (queue_op),
      .empty     (op_empty)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .op_data   (queue_op),
      .op_empty  (op_empty),
      .op_pop    (op_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

// File: rtl/tcw_front.sv
// front end: classifies incoming commands and drops null characters
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_front import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  req_type req_data,
   input  logic    req_push,
   output logic    req_full,
   output op_type  op_data,
   output logic    op_push,
   input  logic    op_full
);

   localparam int CELLS = COLUMNS * ROWS;

   logic is_null;

   always_comb begin
      op_data.char_code  = req_data.char_code;
      op_data.cell_index = req_data.cell_index;
      op_data.in_range   = (32'(req_data.cell_index) < 32'(CELLS));
      if (req_data.cmd == CMD_READ) begin
         op_data.op = OP_READ;
      end else begin
         case (req_data.char_code)
            CODE_NEWLINE:   op_data.op = OP_NEWLINE;
            CODE_BACKSPACE: op_data.op = OP_BACKSPACE;
            default:        op_data.op = OP_PRINT;
         endcase
      end
   end

   // a null put is taken from the input and forgotten
   assign is_null  = (req_data.cmd == CMD_PUT) && (req_data.char_code == CODE_NULL);
   assign req_full = op_full;
   assign op_push  = req_push && !op_full && !is_null;

endmodule

// File: rtl/tcw_opq.sv
// short command queue between front end and executor
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_opq import tcw_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_data,
   output logic   full,
   input  logic   pop,
   output op_type pop_data,
   output logic   empty
);

   localparam int PTR_W = $clog2(OPQ_DEPTH);
   localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

   op_type           entry_ff [OPQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(OPQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/tcw_back.sv
// executor: screen memory, cursor, scroll and clear sequencer, result register
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_back import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  op_type     op_data,
   input  logic       op_empty,
   output logic       op_pop,
   output rsp_type    rsp_data,
   output logic       rsp_empty,
   input  logic       rsp_pop
);

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int COPY_LAST = CELLS - COLUMNS;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_COPY  = 3'd3;
   localparam logic [2:0] ST_BLANK = 3'd4;

   logic [15:0]       mem [CELLS];
   logic [15:0]       rdata_ff;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [7:0]        color_ff;
   op_type            op_ff;
   logic              wpend_ff, wpend_in;
   logic [ADDR_W-1:0] wdst_ff, wdst_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [15:0]       mem_wdata;
   logic              rsp_load, scroll;
   logic [15:0]       value;
   logic              slot_free, at_last_col, at_last_row;
   logic [ADDR_W-1:0] line_start;

   assign slot_free   = !rsp_valid_ff || rsp_pop;
   assign op_pop      = (state_ff == ST_IDLE) && !op_empty && slot_free;
   assign at_last_col = (col_ff == COL_W'(COLUMNS - 1));
   assign at_last_row = (row_ff == ROW_W'(ROWS - 1));
   assign line_start  = pos_ff - ADDR_W'(col_ff);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      pos_in    = pos_ff;
      wpend_in  = 1'b0;
      wdst_in   = wdst_ff;
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = {color_ff, CODE_SPACE};
      mem_raddr = ADDR_W'(op_data.cell_index);
      rsp_load  = 1'b0;
      scroll    = 1'b0;
      value     = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = RESET_CELL;
            if (cnt_ff == ADDR_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (op_pop) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff.op)
               OP_READ: begin
                  value = op_ff.in_range ? rdata_ff : '0;
               end
               OP_PRINT: begin
                  mem_we    = 1'b1;
                  mem_wdata = {color_ff, op_ff.char_code};
                  if (at_last_col) begin
                     col_in = '0;
                     if (at_last_row) begin
                        pos_in = line_start;
                        scroll = 1'b1;
                     end else begin
                        row_in = row_ff + 1'b1;
                        pos_in = pos_ff + 1'b1;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                     pos_in = pos_ff + 1'b1;
                  end
               end
               OP_NEWLINE: begin
                  col_in = '0;
                  if (at_last_row) begin
                     pos_in = line_start;
                     scroll = 1'b1;
                  end else begin
                     row_in = row_ff + 1'b1;
                     pos_in = ADDR_W'(line_start + ADDR_W'(COLUMNS));
                  end
               end
               OP_BACKSPACE: begin
                  // nothing moves at the top left corner
                  if (pos_ff != '0) begin
                     pos_in    = pos_ff - 1'b1;
                     mem_we    = 1'b1;
                     mem_waddr = pos_ff - 1'b1;
                     if (col_ff == '0) begin
                        col_in = COL_W'(COLUMNS - 1);
                        row_in = row_ff - 1'b1;
                     end else begin
                        col_in = col_ff - 1'b1;
                     end
                  end
               end
               default: begin
                  value = '0;
               end
            endcase
            if (scroll) begin
               cnt_in   = '0;
               state_in = ST_COPY;
            end else begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            // read one row ahead, write the returned cell in the next cycle
            if (wpend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wdst_ff;
               mem_wdata = rdata_ff;
            end
            if (cnt_ff == ADDR_W'(COPY_LAST)) begin
               state_in = ST_BLANK;
            end else begin
               mem_raddr = ADDR_W'(cnt_ff + ADDR_W'(COLUMNS));
               wpend_in  = 1'b1;
               wdst_in   = cnt_ff;
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         ST_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            if (cnt_ff == ADDR_W'(CELLS - 1)) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in.cursor_row_out = 5'(row_in);
      rsp_in.cursor_col_out = 7'(col_in);
      rsp_in.cursor_offset  = 11'(pos_in);
      rsp_in.cell_value     = value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         pos_ff       <= '0;
         wpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         color_ff     <= RESET_COLOR;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         pos_ff   <= pos_in;
         wpend_ff <= wpend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            color_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      wdst_ff <= wdst_in;
      if (op_pop) begin
         op_ff <= op_data;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign rsp_data  = rsp_ff;
   assign rsp_empty = !rsp_valid_ff;

endmodule
